### rtl/bta_pkg.sv
// Shared types and constants for the buddy tree allocator.
// Used by bta_ctrl, bta_datapath, buddy_tree_allocator and bta_checker.
package bta_pkg;

   localparam int LEAF_LEVELS  = 10;
   localparam int SIZE_W       = 11;
   localparam int PAGE_W       = 36;
   localparam int NODE_IDX_W   = 11;
   localparam int BLOCK_PAGE_W = 37;
   localparam int STATUS_W     = 2;
   localparam int REQ_DATA_W   = 64;
   localparam int RSP_DATA_W   = 56;
   localparam int CSR_ADDR_W   = 4;
   localparam int CSR_DATA_W   = 64;
   localparam int ENTRY_W      = 5;

   localparam logic [ENTRY_W-1:0] TAKEN_RIGHT = 5'd1;
   localparam logic [ENTRY_W-1:0] TAKEN_LEFT  = 5'd2;
   localparam logic [ENTRY_W-1:0] MERGE_RIGHT = 5'd4;
   localparam logic [ENTRY_W-1:0] MERGE_LEFT  = 5'd8;
   localparam logic [ENTRY_W-1:0] OCC         = 5'd16;
   localparam logic [ENTRY_W-1:0] BUSY_BITS   = OCC | TAKEN_LEFT | TAKEN_RIGHT;

   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

   localparam logic CSR_REG_BASE = 1'b0;

   typedef enum logic [STATUS_W-1:0] {
      RSP_DONE      = 2'd0,
      RSP_NO_FREE   = 2'd1,
      RSP_TOO_LARGE = 2'd2
   } rsp_status_type;

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE, S_DECODE, S_MUL, S_START, S_ADJ, S_SC_RD, S_SC_EV,
      S_CL_UP, S_CL_EV, S_FN_RD, S_FN_EV, S_FN_CLR, S_UM_UP, S_UM_EV, S_FIN
   } state_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_CLEAR, OP_LOAD, OP_DECODE, OP_MUL, OP_START, OP_ADJ,
      OP_SC_RD, OP_SC_EV, OP_CL_UP, OP_CL_EV, OP_FN_INIT_FREE, OP_FN_RD,
      OP_FN_EV, OP_FN_CLR, OP_UM_UP, OP_UM_EV, OP_FIN
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic out_free;
      logic is_free;
      logic free_ok;
      logic size_err;
      logic past_end;
      logic v_nonzero;
      logic cl_more;
      logic occ_hit;
      logic fn_more;
      logic fn_stop;
      logic n_at_upper;
      logic um_root;
      logic um_coal;
      logic um_more;
   } sts_type;

endpackage

### rtl/bta_ctrl.sv
// Sequencer for the buddy tree allocator: clear pass, scan, claim, free, unmark.
// Depends on bta_pkg; drives bta_datapath through cmd_type, reads sts_type.
module bta_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  bta_pkg::sts_type sts,
   output bta_pkg::cmd_type cmd
);
   import bta_pkg::*;

   state_type state_ff, state_in;
   logic      ret_skip_ff, ret_skip_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_CLEAR;
         ret_skip_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         ret_skip_ff <= ret_skip_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      ret_skip_in = ret_skip_ff;
      cmd.op      = OP_NONE;
      req_tready  = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            cmd.op = OP_CLEAR;
            if (sts.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.op   = OP_LOAD;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd.op = OP_DECODE;
            if (sts.is_free) begin
               if (sts.free_ok) begin
                  cmd.op      = OP_FN_INIT_FREE;
                  ret_skip_in = 1'b0;
                  state_in    = S_FN_RD;
               end else begin
                  state_in = S_FIN;
               end
            end else if (sts.size_err) begin
               state_in = S_FIN;
            end else begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            cmd.op   = OP_MUL;
            state_in = S_START;
         end
         S_START: begin
            cmd.op   = OP_START;
            state_in = S_ADJ;
         end
         S_ADJ: begin
            cmd.op   = OP_ADJ;
            state_in = S_SC_RD;
         end
         S_SC_RD: begin
            cmd.op   = OP_SC_RD;
            state_in = sts.past_end ? S_FIN : S_SC_EV;
         end
         S_SC_EV: begin
            cmd.op   = OP_SC_EV;
            state_in = sts.v_nonzero ? S_SC_RD : S_CL_UP;
         end
         S_CL_UP: begin
            cmd.op   = OP_CL_UP;
            state_in = sts.cl_more ? S_CL_EV : S_FIN;
         end
         S_CL_EV: begin
            cmd.op = OP_CL_EV;
            if (sts.occ_hit) begin
               ret_skip_in = 1'b1;
               state_in    = S_FN_RD;
            end else begin
               state_in = S_CL_UP;
            end
         end
         S_FN_RD: begin
            cmd.op   = OP_FN_RD;
            state_in = sts.fn_more ? S_FN_EV : S_FN_CLR;
         end
         S_FN_EV: begin
            cmd.op   = OP_FN_EV;
            state_in = sts.fn_stop ? S_FN_CLR : S_FN_RD;
         end
         S_FN_CLR: begin
            cmd.op = OP_FN_CLR;
            if (!sts.n_at_upper) state_in = S_UM_UP;
            else state_in = ret_skip_ff ? S_SC_RD : S_FIN;
         end
         S_UM_UP: begin
            cmd.op = OP_UM_UP;
            if (sts.um_root) state_in = ret_skip_ff ? S_SC_RD : S_FIN;
            else state_in = S_UM_EV;
         end
         S_UM_EV: begin
            cmd.op = OP_UM_EV;
            if (sts.um_coal && sts.um_more) state_in = S_UM_UP;
            else state_in = ret_skip_ff ? S_SC_RD : S_FIN;
         end
         S_FIN: begin
            if (sts.out_free) begin
               cmd.op   = OP_FIN;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_CLEAR;
      endcase
   end

endmodule

### rtl/bta_datapath.sv
// Datapath of the buddy tree allocator: node status memory, scan and climb
// registers, hint scaling multiplier and result register. Depends on bta_pkg.
module bta_datapath #(
   parameter int TOP_LEVEL   = 4
) (
   input  logic                              clock,
   input  logic                              reset,
   input  bta_pkg::cmd_type                  cmd,
   output bta_pkg::sts_type                  sts,
   input  logic [bta_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic                              req_tuser,
   input  logic [bta_pkg::PAGE_W-1:0]        base_page,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [bta_pkg::RSP_DATA_W-1:0]    rsp_tdata
);
   import bta_pkg::*;

   localparam int NW   = LEAF_LEVELS + 1;
   localparam int LVW  = $clog2(LEAF_LEVELS + 1);
   localparam int LW   = LEAF_LEVELS;
   localparam int NODES = 1 << NW;

   logic [ENTRY_W-1:0] mem [NODES];
   logic [ENTRY_W-1:0] rd_ff;
   logic [NW-1:0]      raddr, waddr;
   logic [ENTRY_W-1:0] wdata;
   logic               we;

   logic                  func_ff;
   logic [SIZE_W-1:0]     size_ff;
   logic [PAGE_W-1:0]     hint_ff;
   logic [NODE_IDX_W-1:0] node_ff;

   logic [NW-1:0]   clr_ff;
   logic [LVW-1:0]  level_ff;
   logic [LW-1:0]   off_ff;
   logic [2*LW-1:0] prod_ff;
   logic [NW-1:0]   start_ff;
   logic [NW:0]     i_ff;
   logic [NW-1:0]   n_ff, cur_ff, run_ff;
   logic [LVW-1:0]  n_lvl_ff, cur_lvl_ff, run_lvl_ff, upper_ff;
   logic            cb_ff;
   rsp_status_type  res_ff;
   logic            grant_ff;

   logic                    rsp_valid_ff;
   logic [STATUS_W-1:0]     rsp_status_ff;
   logic [NODE_IDX_W-1:0]   rsp_node_ff;
   logic [BLOCK_PAGE_W-1:0] rsp_page_ff;

   // decode helpers
   logic [SIZE_W-1:0] sz, szm1;
   logic [3:0]        c_bits, node_msb;
   logic              size_err, free_ok;
   logic [PAGE_W:0]   diff;
   logic [LW-1:0]     off_in;
   logic [NW-1:0]     first;
   logic [NW:0]       last_node;
   logic [LW:0]       adj_lhs;
   logic [ENTRY_W-1:0] nv;
   logic [LW:0]       ofs;

   always_comb begin
      sz   = (size_ff == '0) ? SIZE_W'(1) : size_ff;
      szm1 = sz - SIZE_W'(1);
      c_bits = '0;
      for (int k = 0; k < SIZE_W; k++) begin
         if (szm1[k]) c_bits = 4'(k + 1);
      end
      size_err = int'(c_bits) > (LEAF_LEVELS - TOP_LEVEL);
      node_msb = '0;
      for (int k = 0; k < NODE_IDX_W; k++) begin
         if (node_ff[k]) node_msb = 4'(k);
      end
      free_ok = (node_ff != '0) && ((32'(node_ff) >> NW) == 32'd0)
                && (int'(node_msb) >= TOP_LEVEL);
      diff = {1'b0, hint_ff} - {1'b0, base_page};
      if (diff[PAGE_W]) off_in = '0;
      else if (diff[PAGE_W-1:0] > PAGE_W'((64'd1 << LW) - 64'd1)) off_in = '1;
      else off_in = LW'(diff[PAGE_W-1:0]);
      first     = NW'(1) << level_ff;
      last_node = ((NW+1)'(first) << 1) - (NW+1)'(1);
      adj_lhs   = (LW+1)'(start_ff - first) << (LEAF_LEVELS - int'(level_ff));
      nv        = rd_ff & ~((TAKEN_LEFT | MERGE_LEFT) >> cb_ff);
      ofs       = (LW+1)'(n_ff - first) << (LEAF_LEVELS - int'(level_ff));
   end

   always_comb begin
      sts.clr_last   = &clr_ff;
      sts.out_free   = !rsp_valid_ff || rsp_tready;
      sts.is_free    = (func_ff == FUNC_FREE);
      sts.free_ok    = free_ok;
      sts.size_err   = size_err;
      sts.past_end   = i_ff > last_node;
      sts.v_nonzero  = rd_ff != '0;
      sts.cl_more    = int'(cur_lvl_ff) > TOP_LEVEL;
      sts.occ_hit    = (rd_ff & OCC) != '0;
      sts.fn_more    = (run_lvl_ff > upper_ff) && (cur_ff != '0);
      sts.fn_stop    = ((rd_ff & (TAKEN_RIGHT << run_ff[0])) != '0)
                       && ((rd_ff & (MERGE_RIGHT << run_ff[0])) == '0);
      sts.n_at_upper = n_lvl_ff == upper_ff;
      sts.um_root    = (cur_ff >> 1) == '0;
      sts.um_coal    = (rd_ff & (MERGE_LEFT >> cb_ff)) != '0;
      sts.um_more    = (cur_lvl_ff > upper_ff) && ((nv & (TAKEN_RIGHT << cb_ff)) == '0);
   end

   // memory port selection
   always_comb begin
      raddr = cur_ff;
      waddr = cur_ff;
      wdata = '0;
      we    = 1'b0;
      case (cmd.op)
         OP_CLEAR: begin
            waddr = clr_ff;
            we    = 1'b1;
         end
         OP_SC_RD: raddr = i_ff[NW-1:0];
         OP_SC_EV: begin
            waddr = i_ff[NW-1:0];
            wdata = BUSY_BITS;
            we    = (rd_ff == '0);
         end
         OP_CL_UP: raddr = cur_ff >> 1;
         OP_CL_EV: begin
            wdata = (rd_ff & ~(MERGE_LEFT >> cb_ff)) | (TAKEN_LEFT >> cb_ff);
            we    = !sts.occ_hit;
         end
         OP_FN_RD: raddr = cur_ff;
         OP_FN_EV: begin
            wdata = rd_ff | (MERGE_LEFT >> run_ff[0]);
            we    = 1'b1;
         end
         OP_FN_CLR: begin
            waddr = n_ff;
            we    = 1'b1;
         end
         OP_UM_UP: raddr = cur_ff >> 1;
         OP_UM_EV: begin
            wdata = nv;
            we    = sts.um_coal;
         end
         default: we = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rd_ff <= mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.op == OP_CLEAR) clr_ff <= clr_ff + NW'(1);
         if (cmd.op == OP_FIN) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_LOAD: begin
            func_ff <= req_tuser;
            size_ff <= req_tdata[10:0];
            hint_ff <= req_tdata[46:11];
            node_ff <= req_tdata[57:47];
         end
         OP_DECODE: begin
            res_ff   <= (!sts.is_free && size_err) ? RSP_TOO_LARGE : RSP_DONE;
            grant_ff <= 1'b0;
            level_ff <= LVW'(LEAF_LEVELS - int'(c_bits));
            off_ff   <= off_in;
         end
         OP_FN_INIT_FREE: begin
            res_ff     <= RSP_DONE;
            grant_ff   <= 1'b0;
            n_ff       <= NW'(node_ff);
            n_lvl_ff   <= LVW'(node_msb);
            run_ff     <= NW'(node_ff);
            run_lvl_ff <= LVW'(node_msb);
            cur_ff     <= NW'(node_ff) >> 1;
            upper_ff   <= LVW'(TOP_LEVEL);
         end
         OP_MUL: prod_ff <= (2*LW)'(LW'(first - NW'(1))) * (2*LW)'(off_ff);
         OP_START: start_ff <= first + NW'(prod_ff >> LW);
         OP_ADJ: begin
            if (adj_lhs < (LW+1)'(off_ff)) i_ff <= (NW+1)'(start_ff) + (NW+1)'(1);
            else i_ff <= (NW+1)'(start_ff);
         end
         OP_SC_RD: if (sts.past_end) res_ff <= RSP_NO_FREE;
         OP_SC_EV: begin
            if (rd_ff != '0) begin
               i_ff <= i_ff + (NW+1)'(1);
            end else begin
               n_ff       <= i_ff[NW-1:0];
               n_lvl_ff   <= level_ff;
               cur_ff     <= i_ff[NW-1:0];
               cur_lvl_ff <= level_ff;
            end
         end
         OP_CL_UP: begin
            if (sts.cl_more) begin
               cb_ff      <= cur_ff[0];
               cur_ff     <= cur_ff >> 1;
               cur_lvl_ff <= cur_lvl_ff - LVW'(1);
            end else begin
               grant_ff <= 1'b1;
            end
         end
         OP_CL_EV: begin
            if (sts.occ_hit) begin
               // skip the whole subtree under the occupied ancestor
               i_ff <= ((NW+1)'(cur_ff) + (NW+1)'(1)) << (level_ff - cur_lvl_ff);
               upper_ff   <= cur_lvl_ff + LVW'(1);
               run_ff     <= n_ff;
               run_lvl_ff <= n_lvl_ff;
               cur_ff     <= n_ff >> 1;
            end
         end
         OP_FN_EV: begin
            if (!sts.fn_stop) begin
               run_ff     <= cur_ff;
               run_lvl_ff <= run_lvl_ff - LVW'(1);
               cur_ff     <= cur_ff >> 1;
            end
         end
         OP_FN_CLR: begin
            cur_ff     <= n_ff;
            cur_lvl_ff <= n_lvl_ff;
         end
         OP_UM_UP: begin
            cb_ff      <= cur_ff[0];
            cur_ff     <= cur_ff >> 1;
            cur_lvl_ff <= cur_lvl_ff - LVW'(1);
         end
         OP_FIN: begin
            rsp_status_ff <= res_ff;
            if (grant_ff) begin
               rsp_node_ff <= NODE_IDX_W'(n_ff);
               rsp_page_ff <= BLOCK_PAGE_W'(base_page) + BLOCK_PAGE_W'(ofs);
            end else begin
               rsp_node_ff <= '0;
               rsp_page_ff <= '0;
            end
         end
         default: ;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_page_ff, rsp_node_ff, rsp_status_ff};

endmodule

### rtl/buddy_tree_allocator.sv
// Top level of the buddy tree allocator: streaming ports, APB register port.
// Depends on bta_pkg, bta_ctrl and bta_datapath.
//
// Buddy allocator over a binary tree of 2^(LEAF_LEVELS+1) five-bit node
// status entries held in one memory with one read and one write port;
// LEAF_LEVELS is a package constant tied to the port widths. After reset
// the block runs a clearing pass over the memory and takes no request
// beat until it ends; register writes are taken throughout.
// Items are handled one at a time. An allocate takes the beat, decodes
// it and scales the hint (one multiplier), then scans the nodes of its
// level and marks the ancestors of the node it claims; a rollback runs
// the same release steps as a free. A free makes two climbs: coalescing
// marks are set on the way up, and occupancy marks are cleared after the
// node is released. Both end by loading the result register. A finished
// result sits in an output register, so the next request beat is taken
// while it waits.
module buddy_tree_allocator #(
   parameter int TOP_LEVEL   = 4
) (
   input  logic                              clock,
   input  logic                              reset,
   // req_tdata: size_pages[10:0], hint_page[46:11], node_index[57:47], zero fill
   input  logic [bta_pkg::REQ_DATA_W-1:0]    req_tdata,
   // req_tuser: func (0 allocate, 1 free)
   input  logic                              req_tuser,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // rsp_tdata: status[1:0], granted_node[12:2], block_page[49:13], zero fill
   output logic [bta_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [bta_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [bta_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [bta_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);
   import bta_pkg::*;

   logic [PAGE_W-1:0] base_ff;
   cmd_type           cmd;
   sts_type           sts;

   // region base register, byte address 0
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready
                   && (csr_paddr[3] == CSR_REG_BASE)) begin
         base_ff <= csr_pwdata[PAGE_W-1:0];
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[3] == CSR_REG_BASE) ? CSR_DATA_W'(base_ff) : '0;

   bta_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   bta_datapath #(
      .TOP_LEVEL   (TOP_LEVEL)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .base_page  (base_ff),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

### rtl/bta_checker.sv
// Port-level checks for buddy_tree_allocator, attached by bind.
// Depends on bta_pkg.
module bta_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [bta_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import bta_pkg::*;

   // clearing pass follows reset
   a_clear_after_reset: assert property (@(posedge clock) reset |=> !req_tready)
      else $error("request taken during clearing pass");

   // one item at a time
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second request taken while busy");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled response changed");

   a_fail_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tdata[1:0] != RSP_DONE)) |->
      (rsp_tdata[49:2] == '0))
      else $error("failed response carries a grant");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[1:0] == RSP_DONE || rsp_tdata[1:0] == RSP_NO_FREE
                      || rsp_tdata[1:0] == RSP_TOO_LARGE))
      else $error("undefined status code");

endmodule

bind buddy_tree_allocator bta_checker u_bta_checker (.*);

### dv/tb_buddy_tree_allocator.sv
// Self-checking testbench for buddy_tree_allocator: streaming requests and
// results are checked against a behavioral buddy tree. Depends on bta_pkg.

module tb_buddy_tree_allocator;
   timeunit 1ns;
   timeprecision 1ps;
   import bta_pkg::*;

   localparam int LEAVES    = 10;
   localparam int TOP_LVL   = 4;
   localparam int NODES     = 1 << (LEAVES + 1);
   localparam longint PAGES = 1 << LEAVES;
   localparam int WATCHDOG  = 200000;

   // Expected beats held by the scoreboard.
   typedef struct packed {
      logic [STATUS_W-1:0]     status;
      logic [NODE_IDX_W-1:0]   node;
      logic [BLOCK_PAGE_W-1:0] page;
   } alloc_result_type;

   // Behavioral buddy tree plus the queue of results it predicts.
   class alloc_scoreboard;
      logic [ENTRY_W-1:0] tree [NODES];
      logic [PAGE_W-1:0]  base;
      alloc_result_type   pending [$];
      int                 mismatches;
      int                 checked;

      function void clear_tree();
         foreach (tree[i]) tree[i] = '0;
         base = '0;
      endfunction

      function int depth(longint n);
         int l;
         l = 0;
         while (n > 1) begin
            n = n >> 1;
            l++;
         end
         return l;
      endfunction

      function void climb_clear(longint n, int upper);
         longint cur, child;
         logic [ENTRY_W-1:0] v, nv;
         cur = n;
         forever begin
            child = cur;
            cur = cur >> 1;
            if (cur == 0) return;
            v = tree[cur];
            if ((v & (MERGE_LEFT >> child[0])) == 0) return;
            nv = v & ~((TAKEN_LEFT | MERGE_LEFT) >> child[0]);
            tree[cur] = nv;
            if (!(depth(cur) > upper && (nv & (TAKEN_RIGHT << child[0])) == 0)) return;
         end
      endfunction

      function void release_node(longint n, int upper);
         longint cur, run;
         logic [ENTRY_W-1:0] v;
         cur = n >> 1;
         run = n;
         while (depth(run) > upper && cur != 0) begin
            v = tree[cur];
            tree[cur] = v | (MERGE_LEFT >> run[0]);
            if ((v & (TAKEN_RIGHT << run[0])) != 0 && (v & (MERGE_RIGHT << run[0])) == 0)
               break;
            run = cur;
            cur = cur >> 1;
         end
         tree[n] = '0;
         if (depth(n) != upper) climb_clear(n, upper);
      endfunction

      // Zero on success, else the node itself if it is not empty, or the ancestor that blocked the claim.
      function longint claim(longint n);
         longint cur, child;
         logic [ENTRY_W-1:0] v;
         cur = n;
         if (tree[n] != 0) return n;
         tree[n] = BUSY_BITS;
         while (depth(cur) > TOP_LVL) begin
            child = cur;
            cur = cur >> 1;
            v = tree[cur];
            if ((v & OCC) != 0) begin
               release_node(n, depth(child));
               return cur;
            end
            v = v & ~(MERGE_LEFT >> child[0]);
            v = v | (TAKEN_LEFT >> child[0]);
            tree[cur] = v;
         end
         return 0;
      endfunction

      function void note_request(logic func, logic [SIZE_W-1:0] size_in,
                                 logic [PAGE_W-1:0] hint, logic [NODE_IDX_W-1:0] idx);
         alloc_result_type r;
         longint sz, first, last, start, off, blk, i, f;
         int c, level;
         r = '0;
         if (func == FUNC_FREE) begin
            if (idx != 0 && depth(idx) >= TOP_LVL) release_node(idx, TOP_LVL);
            pending.push_back(r);
            return;
         end
         sz = size_in;
         if (sz == 0) sz = 1;
         c = 0;
         while ((64'd1 << c) < sz) c++;
         level = LEAVES - c;
         if (sz > PAGES || level < TOP_LVL) begin
            r.status = RSP_TOO_LARGE;
            pending.push_back(r);
            return;
         end
         blk = PAGES >> level;
         first = 64'd1 << level;
         last = 2 * first - 1;
         off = (hint >= base) ? longint'(hint) - longint'(base) : 0;
         if (off > PAGES - 1) off = PAGES - 1;
         start = first + ((first - 1) * off) / PAGES;
         if ((start - first) * blk < off) start++;
         i = start;
         while (i <= last) begin
            if ((tree[i] & BUSY_BITS) == 0) begin
               f = claim(i);
               if (f == 0) begin
                  r.node = NODE_IDX_W'(i);
                  r.page = BLOCK_PAGE_W'(longint'(base) + (i - first) * blk);
                  pending.push_back(r);
                  return;
               end
               i = (f + 1) << (depth(i) - depth(f));
            end else begin
               i++;
            end
         end
         r.status = RSP_NO_FREE;
         pending.push_back(r);
      endfunction

      function void check_result(logic [RSP_DATA_W-1:0] beat);
         alloc_result_type exp_r, got;
         got.status = beat[1:0];
         got.node   = beat[12:2];
         got.page   = beat[49:13];
         checked++;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result beat %h", beat);
            return;
         end
         exp_r = pending.pop_front();
         if (got !== exp_r || beat[RSP_DATA_W-1:50] !== '0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: exp status %0d node %0d page %h, got status %0d node %0d page %h",
                        exp_r.status, exp_r.node, exp_r.page, got.status, got.node, got.page);
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic req_tuser = 0, req_tvalid = 0, req_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic rsp_tvalid, rsp_tready = 0;
   logic csr_psel = 0, csr_penable = 0, csr_pwrite = 0, csr_pready;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0, csr_prdata;

   alloc_scoreboard sb;
   bit   calm_tail;     // no idling in the last stretch
   bit   stall_long;    // hold off the receiver for a long stretch
   int   idle_cycles;
   int   allocs_done, frees_done;

   always #10 clock = ~clock;

   buddy_tree_allocator dut (.*);

   // Check every accepted result beat.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
   end

   // Receiver: random stall bursts, plus one long hold-off on request.
   initial begin
      int n;
      forever begin
         @(posedge clock);
         if (stall_long) begin
            rsp_tready <= 0;
            repeat (3000) @(posedge clock);
            stall_long = 0;
         end
         if (!calm_tail && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 0;
            n = $urandom_range(1, 10);
            repeat (n - 1) @(posedge clock);
         end else begin
            rsp_tready <= 1;
         end
      end
   end

   // Watchdog: count cycles with no beat on either channel.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
         $display("watchdog expired with %0d results pending", sb.pending.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Write a register through setup and access phases.
   task automatic csr_write(logic [CSR_ADDR_W-1:0] addr, logic [CSR_DATA_W-1:0] data);
      csr_psel <= 1; csr_penable <= 0; csr_pwrite <= 1;
      csr_paddr <= addr; csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
      sb.base = data[PAGE_W-1:0];
   endtask

   // Offer one beat, hold it until accepted, then note it in the scoreboard.
   task automatic send_beat(logic func, logic [SIZE_W-1:0] sz,
                            logic [PAGE_W-1:0] hint, logic [NODE_IDX_W-1:0] idx);
      int n;
      if (!calm_tail && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 0;
         n = $urandom_range(1, 10);
         repeat (n) @(posedge clock);
      end
      req_tdata  <= {6'd0, idx, hint, sz};
      req_tuser  <= func;
      req_tvalid <= 1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(func, sz, hint, idx);
      if (func == FUNC_FREE) frees_done++; else allocs_done++;
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);   // settle before the register changes
   endtask

   function automatic logic [SIZE_W-1:0] pick_size();
      int lg;
      lg = $urandom_range(0, 6);
      case ($urandom_range(0, 9))
         0: return SIZE_W'($urandom_range(0, 2047));
         1: return 11'd1024;
         default: return SIZE_W'($urandom_range((1 << lg) / 2 + 1, 1 << lg));
      endcase
   endfunction

   // Page near the region, sometimes anywhere in the 36-bit space.
   function automatic logic [PAGE_W-1:0] pick_hint();
      if ($urandom_range(0, 7) == 0) return PAGE_W'({$urandom, $urandom});
      return sb.base + PAGE_W'($urandom_range(0, 1100)) - PAGE_W'(40);
   endfunction

   // Free a node that is likely live: a leaf-ish index at a usable level.
   function automatic logic [NODE_IDX_W-1:0] pick_node(logic [NODE_IDX_W-1:0] last_granted);
      case ($urandom_range(0, 5))
         0: return NODE_IDX_W'($urandom_range(0, 2047));
         1, 2: return last_granted;
         default: return NODE_IDX_W'($urandom_range(16, 2047));
      endcase
   endfunction

   initial begin
      logic [NODE_IDX_W-1:0] granted [$];
      logic [NODE_IDX_W-1:0] pick;
      logic [CSR_DATA_W-1:0] bases [4];
      int k;
      sb = new();
      sb.clear_tree();
      repeat (11) @(posedge clock);
      reset <= 0;
      bases[0] = 64'd0;
      bases[1] = 64'hF_FFFF_FFFF;
      bases[2] = 64'd1000;
      bases[3] = {$urandom, $urandom} & 64'hF_FFFF_FFFF;

      // Directed: size extremes, zero size, out-of-range hints, invalid frees.
      csr_write({CSR_REG_BASE, 3'b000}, 64'd0);
      send_beat(FUNC_ALLOC, 11'd0, 36'd0, 11'd0);
      send_beat(FUNC_ALLOC, 11'd1, 36'hF_FFFF_FFFF, 11'h7FF);
      send_beat(FUNC_ALLOC, 11'd1024, 36'd0, 11'd0);
      send_beat(FUNC_ALLOC, 11'd64, 36'd500, 11'd0);
      send_beat(FUNC_ALLOC, 11'd65, 36'd0, 11'd0);
      send_beat(FUNC_ALLOC, 11'd1025, 36'd0, 11'd0);
      send_beat(FUNC_ALLOC, 11'h7FF, 36'd0, 11'd0);
      for (k = 0; k < 18; k++) send_beat(FUNC_ALLOC, 11'd64, 36'd0, 11'd0);
      send_beat(FUNC_FREE, 11'h7FF, 36'hF_FFFF_FFFF, 11'd0);
      send_beat(FUNC_FREE, 11'd0, 36'd0, 11'd3);
      send_beat(FUNC_FREE, 11'd0, 36'd0, 11'd16);
      send_beat(FUNC_FREE, 11'd0, 36'd0, 11'd2047);
      send_beat(FUNC_FREE, 11'd0, 36'd0, 11'd20);

      // Random phases under several base settings, extremes included.
      for (int ph = 0; ph < 4; ph++) begin
         drain();
         csr_write({CSR_REG_BASE, 3'b000}, bases[ph]);
         if (ph == 1) stall_long = 1;
         if (ph == 3) calm_tail = 1;
         for (k = 0; k < 320; k++) begin
            if ($urandom_range(0, 1) == 0 || granted.size() == 0) begin
               send_beat(FUNC_ALLOC, pick_size(), pick_hint(), NODE_IDX_W'($urandom));
               if (sb.pending[$].status == RSP_DONE) granted.push_back(sb.pending[$].node);
            end else begin
               pick = granted[$urandom_range(0, granted.size() - 1)];
               send_beat(FUNC_FREE, SIZE_W'($urandom), PAGE_W'({$urandom, $urandom}),
                         pick_node(pick));
            end
         end
      end
      drain();

      $display("covered %0d allocates and %0d frees over four region bases; %0d results checked",
               allocs_done, frees_done, sb.checked);
      if (sb.mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("%0d mismatches", sb.mismatches);
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
